/* rtl/core/tdpd_pkg.sv */
// Shared types, constants and the signature table for the tape dump pulse decoder.
`timescale 1ns / 1ps

package tdpd_pkg;

    // Header layout
    localparam int HEADER_BYTES = 20;
    localparam int SIG_LEN      = 12;
    localparam int VERSION_POS  = 12;
    localparam int WIDTH_POS    = 15;
    localparam int RATE_POS     = 16;

    // Result codes
    typedef enum logic [1:0] {
        KIND_HDR_OK  = 2'd0,
        KIND_PULSE   = 2'd1,
        KIND_HDR_BAD = 2'd2,
        KIND_OVER    = 2'd3
    } kind_t;

    // One result as it leaves a decode unit
    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [31:0] value;
        logic [5:0]  bits;
    } result_t;

    // Expected signature character at a header position
    function automatic logic [7:0] sig_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = 8'h44;
            5'd1:    c = 8'h43;
            5'd2:    c = 8'h32;
            5'd3:    c = 8'h4E;
            5'd4:    c = 8'h2D;
            5'd5:    c = 8'h54;
            5'd6:    c = 8'h41;
            5'd7:    c = 8'h50;
            5'd8:    c = 8'h2D;
            5'd9:    c = 8'h52;
            5'd10:   c = 8'h41;
            5'd11:   c = 8'h57;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/tape_dump_pulse_decoder_top.sv */
// Top level of the tape dump pulse decoder: handshake, unit select and result register.
//
// Usage:
//   s_ channel: one dump byte per request (s_data_byte). The first 20 bytes are
//   the header; after a good header every further byte belongs to a sample.
//   m_ channel: one request per result with m_kind, m_value, m_sample_bits.
//   A header gives a result on its last byte (accepted or invalid); a bad
//   header restarts parsing at the next byte. A completed sample gives a pulse,
//   an above-limit error or nothing.
// Timing:
//   One byte is taken every cycle while s_ready is high. A result appears on the
//   m_ channel in the cycle after the byte that caused it is accepted. All decode
//   work for a byte sits between the input handshake and the single result register.
// Stall:
//   While a result waits and m_ready is low, s_ready is low; when m_ready is
//   high a new byte is taken in the same cycle the waiting result leaves.
// Reset:
//   aresetn is synchronous, active low; it drops any pending result and
//   returns to header parsing with an empty pulse sum.
`timescale 1ns / 1ps

module tape_dump_pulse_decoder_top
    import tdpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_value,
    output logic [5:0]  m_sample_bits
);

    logic        accept;
    logic        hdr_done;
    logic [5:0]  width;
    logic        hdr_en;
    logic        smp_en;
    logic        smp_clear;
    result_t     hdr_res;
    result_t     smp_res;
    result_t     res;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  kind_reg;
    logic [31:0] value_reg;
    logic [5:0]  bits_reg;

    // Handshake and unit select
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign hdr_en    = accept && !hdr_done;
    assign smp_en    = accept && hdr_done;
    assign smp_clear = hdr_en && hdr_res.valid && (hdr_res.kind == KIND_HDR_OK);
    assign res       = hdr_done ? smp_res : hdr_res;

    tdpd_header u_header (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (hdr_en),
        .data_byte (s_data_byte),
        .done      (hdr_done),
        .width     (width),
        .res       (hdr_res)
    );

    tdpd_sample u_sample (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (smp_en),
        .clear     (smp_clear),
        .width     (width),
        .data_byte (s_data_byte),
        .res       (smp_res)
    );

    // Result register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = res.valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept && res.valid) begin
            kind_reg  <= res.kind;
            value_reg <= res.value;
            bits_reg  <= res.bits;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_value       = value_reg;
    assign m_sample_bits = bits_reg;

    // A request that yields a result is presented on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.valid |=> m_valid)
        else $error("result lost after accepted request");

    // Header accepted carries a legal sample width
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_HDR_OK |-> m_sample_bits >= 6'd1 && m_sample_bits <= 6'd32)
        else $error("accepted header with bad sample width");

    // Only the header-accepted result carries a sample width
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_HDR_OK |-> m_sample_bits == 6'd0)
        else $error("sample width on non-header result");

    // Once the header is accepted, parsing never returns to the header
    assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_done |=> hdr_done)
        else $error("header state dropped without reset");

    // Header results only come from the header parser
    assert property (@(posedge aclk) disable iff (!aresetn)
        smp_en && smp_res.valid |-> smp_res.kind == KIND_PULSE || smp_res.kind == KIND_OVER)
        else $error("sample unit produced a header result");

endmodule

/* rtl/core/tdpd_header.sv */
// Header parser: signature, version and sample width checks, and sample rate capture.
`timescale 1ns / 1ps

module tdpd_header
    import tdpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [7:0]  data_byte,
    output logic        done,
    output logic [5:0]  width,
    output result_t     res
);

    logic        done_reg,  done_next;
    logic [4:0]  pos_reg,   pos_next;
    logic        ok_reg,    ok_next;
    logic [5:0]  width_reg, width_next;
    logic [31:0] rate_reg,  rate_next;
    logic        last;
    logic        good;

    // Field checks and end-of-header decision
    always_comb begin
        done_next  = done_reg;
        pos_next   = pos_reg;
        ok_next    = ok_reg;
        width_next = width_reg;
        rate_next  = rate_reg;
        res        = '0;
        good       = 1'b0;
        last       = (pos_reg == 5'(HEADER_BYTES - 1));

        if (pos_reg < 5'(SIG_LEN)) begin
            if (data_byte != sig_char(pos_reg)) ok_next = 1'b0;
        end else if (pos_reg == 5'(VERSION_POS)) begin
            if (data_byte != 8'd0) ok_next = 1'b0;
        end else if (pos_reg == 5'(WIDTH_POS)) begin
            if (data_byte inside {[8'd1:8'd32]}) begin
                width_next = data_byte[5:0];
            end else begin
                width_next = 6'd0;
                ok_next    = 1'b0;
            end
        end else if (pos_reg >= 5'(RATE_POS)) begin
            rate_next = {data_byte, rate_reg[31:8]};
        end

        if (last) begin
            good = ok_next && (width_next inside {[6'd1:6'd32]});
            res.valid = 1'b1;
            pos_next  = 5'd0;
            if (good) begin
                done_next = 1'b1;
                res.kind  = KIND_HDR_OK;
                res.value = rate_next;
                res.bits  = width_next;
            end else begin
                // restart parsing with the next byte
                ok_next    = 1'b1;
                width_next = 6'd0;
                rate_next  = 32'd0;
                res.kind   = KIND_HDR_BAD;
            end
        end else begin
            pos_next = pos_reg + 5'd1;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= 1'b0;
            pos_reg   <= 5'd0;
            ok_reg    <= 1'b1;
            width_reg <= 6'd0;
            rate_reg  <= 32'd0;
        end else if (en) begin
            done_reg  <= done_next;
            pos_reg   <= pos_next;
            ok_reg    <= ok_next;
            width_reg <= width_next;
            rate_reg  <= rate_next;
        end
    end

    assign done  = done_reg;
    assign width = width_reg;

endmodule

/* rtl/core/tdpd_sample.sv */
// Sample assembler and pulse accumulator for the data part of the dump.
`timescale 1ns / 1ps

module tdpd_sample
    import tdpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        clear,
    input  logic [5:0]  width,
    input  logic [7:0]  data_byte,
    output result_t     res
);

    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] sum_reg, sum_next;
    logic [5:0]  width_m1;
    logic [1:0]  last_cnt;
    logic [31:0] limit;
    logic [31:0] sample;
    logic [31:0] sum_add;

    // Byte count and limit from the sample width
    always_comb begin
        width_m1 = width - 6'd1;
        if (width == 6'd0 || width > 6'd32) begin
            last_cnt = 2'd0;
            limit    = 32'd0;
        end else begin
            last_cnt = width_m1[4:3];
            limit    = (width == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
        end
    end

    // Assemble little-endian, classify on the last byte
    always_comb begin
        sample   = asm_reg | ({24'd0, data_byte} << {cnt_reg, 3'b000});
        sum_add  = sum_reg + sample;
        cnt_next = cnt_reg;
        asm_next = asm_reg;
        sum_next = sum_reg;
        res      = '0;
        if (cnt_reg != last_cnt) begin
            cnt_next = cnt_reg + 2'd1;
            asm_next = sample;
        end else begin
            cnt_next = 2'd0;
            asm_next = 32'd0;
            sum_next = sum_add;
            if (sample > limit) begin
                res.valid = 1'b1;
                res.kind  = KIND_OVER;
            end else if (sample < limit) begin
                res.valid = 1'b1;
                res.kind  = KIND_PULSE;
                res.value = sum_add;
                sum_next  = 32'd0;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            cnt_reg <= 2'd0;
            asm_reg <= 32'd0;
            sum_reg <= 32'd0;
        end else if (en) begin
            cnt_reg <= cnt_next;
            asm_reg <= asm_next;
            sum_reg <= sum_next;
        end
    end

endmodule
